[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the GHASH accumulator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// plain property check, disabled while reset is held
`define GHA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ghash accumulator check failed");
// same-cycle implication check, disabled while reset is held
`define GHA_ASSERT_IMPL(lbl, clk, rst_n, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("ghash accumulator check failed");
`else
`define GHA_ASSERT(lbl, clk, rst_n, prop)
`define GHA_ASSERT_IMPL(lbl, clk, rst_n, cond, expr)
`endif
`endif

[rtl/gha_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha_pkg
// Types and constants shared by the GHASH accumulator modules.
// ----------------------------------------------------------------------------
package gha_pkg;

    // block geometry
    localparam int BLOCK_BITS  = 128;
    localparam int BLOCK_BYTES = 16;
    localparam int HALF_BITS   = 64;
    localparam int COUNT_W     = 5;

    // multiplier digit: key-shift steps per cycle
    localparam int DIGIT_BITS = 8;
    localparam int STEPS      = BLOCK_BITS / DIGIT_BITS;
    localparam int STEP_W     = $clog2(STEPS);

    // reduction term of the reflected field polynomial
    localparam logic [BLOCK_BITS-1:0] GF_POLY = {8'hE1, 120'd0};

    // command queue depth, power of two
    localparam int QUEUE_DEPTH = 4;

    // input operation codes
    localparam logic [1:0] OP_AAD    = 2'd0;
    localparam logic [1:0] OP_CIPHER = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HI = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LO = 1'd1;

    // command from front end to multiplier engine
    typedef struct packed {
        logic                  emit;  // finish: emit hash and clear
        logic [BLOCK_BITS-1:0] blk;   // padded block or length block
    } t_cmd;

endpackage

[rtl/gha_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha_front
// Accepts input transactions, pads short blocks, keeps the section byte
// counters and builds the length block on finish.
// ----------------------------------------------------------------------------
module gha_front #(
    parameter int LEN_COUNT_BITS = 61
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic                         i_full,
    input  logic [1:0]                   i_op,
    input  logic [gha_pkg::HALF_BITS-1:0] i_data_hi,
    input  logic [gha_pkg::HALF_BITS-1:0] i_data_lo,
    input  logic [gha_pkg::COUNT_W-1:0]  i_byte_count,
    output logic                         o_cmd_push,
    output gha_pkg::t_cmd                o_cmd
);

    logic [LEN_COUNT_BITS-1:0] r_aad_bytes, n_aad_bytes;
    logic [LEN_COUNT_BITS-1:0] r_cipher_bytes, n_cipher_bytes;

    logic                               accept;
    logic                               is_finish;
    logic                               is_data;
    logic [gha_pkg::COUNT_W-1:0]        n_eff;
    logic [gha_pkg::BLOCK_BITS-1:0]     raw_blk;
    logic [gha_pkg::BLOCK_BITS-1:0]     pad_blk;
    logic [gha_pkg::HALF_BITS-1:0]      abits;
    logic [gha_pkg::HALF_BITS-1:0]      cbits;

    assign accept    = i_push && !i_full;
    assign is_finish = (i_op == gha_pkg::OP_FINISH);
    assign is_data   = ((i_op == gha_pkg::OP_AAD) || (i_op == gha_pkg::OP_CIPHER))
                       && (i_byte_count != '0);

    // clamp oversized counts to a full block
    assign n_eff = (i_byte_count > gha_pkg::COUNT_W'(gha_pkg::BLOCK_BYTES))
                   ? gha_pkg::COUNT_W'(gha_pkg::BLOCK_BYTES) : i_byte_count;

    // zero bytes past the count; byte 0 is the top byte of data_hi
    assign raw_blk = {i_data_hi, i_data_lo};
    always_comb begin
        for (int b = 0; b < gha_pkg::BLOCK_BYTES; b++) begin
            pad_blk[gha_pkg::BLOCK_BITS-1-8*b -: 8] =
                (gha_pkg::COUNT_W'(b) < n_eff) ? raw_blk[gha_pkg::BLOCK_BITS-1-8*b -: 8]
                                               : 8'h00;
        end
    end

    // bit lengths for the finish block
    assign abits = gha_pkg::HALF_BITS'(r_aad_bytes) << 3;
    assign cbits = gha_pkg::HALF_BITS'(r_cipher_bytes) << 3;

    // command to the queue; ignored items produce nothing
    assign o_cmd_push = accept && (is_finish || is_data);
    assign o_cmd.emit = is_finish;
    assign o_cmd.blk  = is_finish ? {abits, cbits} : pad_blk;

    // section byte counters, wrapping
    always_comb begin
        n_aad_bytes    = r_aad_bytes;
        n_cipher_bytes = r_cipher_bytes;
        if (accept && is_finish) begin
            n_aad_bytes    = '0;
            n_cipher_bytes = '0;
        end else if (accept && is_data && (i_op == gha_pkg::OP_AAD)) begin
            n_aad_bytes = r_aad_bytes + LEN_COUNT_BITS'(n_eff);
        end else if (accept && is_data) begin
            n_cipher_bytes = r_cipher_bytes + LEN_COUNT_BITS'(n_eff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aad_bytes    <= '0;
            r_cipher_bytes <= '0;
        end else begin
            r_aad_bytes    <= n_aad_bytes;
            r_cipher_bytes <= n_cipher_bytes;
        end
    end

endmodule

[rtl/gha_fifo.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// gha_fifo
// Short command queue between the front end and the multiplier engine.
// ----------------------------------------------------------------------------
module gha_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gha_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output gha_pkg::t_cmd o_data
);

    localparam int PTR_W = $clog2(gha_pkg::QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    gha_pkg::t_cmd r_mem [gha_pkg::QUEUE_DEPTH];

    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(gha_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // pointers wrap naturally, depth is a power of two
    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + PTR_W'(1) : r_rd_ptr;
        n_count  = r_count + CNT_W'(i_push) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // no overflow, no underflow
    `GHA_ASSERT_IMPL(a_no_push_full, i_clk, i_rst_n, i_push, !o_full)
    `GHA_ASSERT_IMPL(a_no_pop_empty, i_clk, i_rst_n, i_pop, o_valid)

endmodule

[rtl/gha_engine.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// gha_engine
// Digit-serial GF(2^128) multiplier: XORs a block into the accumulator,
// multiplies by H eight bits per cycle, and emits the hash on finish.
// ----------------------------------------------------------------------------
module gha_engine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [gha_pkg::BLOCK_BITS-1:0] i_key,
    input  logic                           i_cmd_valid,
    input  gha_pkg::t_cmd                  i_cmd,
    output logic                           o_cmd_pop,
    output logic                           o_res_valid,
    output logic [gha_pkg::BLOCK_BITS-1:0] o_res,
    input  logic                           i_res_pop
);

    localparam int BW = gha_pkg::BLOCK_BITS;

    logic                          r_busy, n_busy;
    logic [gha_pkg::STEP_W-1:0]    r_step, n_step;
    logic                          r_emit;
    logic [BW-1:0]                 r_x, r_z, r_v;
    logic [BW-1:0]                 r_acc, n_acc;
    logic                          r_out_valid, n_out_valid;
    logic [BW-1:0]                 r_out;

    logic          start;
    logic          active;
    logic          last;
    logic          done;
    logic          cur_emit;
    logic [BW-1:0] x_op, z_op, v_op;
    logic [BW-1:0] x_nx, z_nx, v_nx;

    // take a command when idle; a finish needs the result slot free
    assign start = !r_busy && i_cmd_valid
                   && (!i_cmd.emit || !r_out_valid || i_res_pop);
    assign active    = r_busy || start;
    assign last      = (r_step == gha_pkg::STEP_W'(gha_pkg::STEPS - 1));
    assign done      = active && last;
    assign cur_emit  = r_busy ? r_emit : i_cmd.emit;
    assign o_cmd_pop = start;

    // operand select: first digit comes straight from the queue
    always_comb begin
        if (r_busy) begin
            x_op = r_x;
            z_op = r_z;
            v_op = r_v;
        end else begin
            x_op = r_acc ^ i_cmd.blk;
            z_op = '0;
            v_op = i_key;
        end
    end

    // one digit: per bit, add V if set, then V times x with reduction
    always_comb begin
        logic carry;
        z_nx = z_op;
        v_nx = v_op;
        for (int j = 0; j < gha_pkg::DIGIT_BITS; j++) begin
            if (x_op[BW-1-j]) begin
                z_nx = z_nx ^ v_nx;
            end
            carry = v_nx[0];
            v_nx  = {1'b0, v_nx[BW-1:1]} ^ (carry ? gha_pkg::GF_POLY : '0);
        end
        x_nx = x_op << gha_pkg::DIGIT_BITS;
    end

    // control and accumulator
    always_comb begin
        n_busy      = r_busy;
        n_step      = r_step;
        n_acc       = r_acc;
        n_out_valid = r_out_valid && !i_res_pop;
        if (active) begin
            n_busy = !last;
            n_step = last ? '0 : r_step + gha_pkg::STEP_W'(1);
        end
        if (done) begin
            n_acc = cur_emit ? '0 : z_nx;
            if (cur_emit) begin
                n_out_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_step      <= n_step;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (active) begin
            r_x <= x_nx;
            r_z <= z_nx;
            r_v <= v_nx;
        end
        if (start) begin
            r_emit <= i_cmd.emit;
        end
        if (done && cur_emit) begin
            r_out <= z_nx;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // checks
    `GHA_ASSERT_IMPL(a_step_idle, i_clk, i_rst_n, r_step != '0, r_busy)
    `GHA_ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, done && cur_emit,
                     !r_out_valid || i_res_pop)
    `GHA_ASSERT(a_emit_clears, i_clk, i_rst_n,
                done && cur_emit |=> r_out_valid && r_acc == '0)
    `GHA_ASSERT(a_busy_holds, i_clk, i_rst_n, r_busy && !last |=> r_busy && !start)

endmodule

[rtl/ghash_accumulator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghash_accumulator
// GCM GHASH engine: absorbs padded 128-bit blocks and emits the hash.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue (push/full): op, data_hi/data_lo, byte_count. A block is
//   zero-padded past byte_count and counted into its section; op 3 and a
//   zero-count data block are dropped. Finish absorbs the bit-length block.
//   Result queue (empty/pop): hash_hi/hash_lo, one per finish transaction.
//   Config channel (i_cfg_valid/o_cfg_ready): index 0 key high half,
//   index 1 key low half; always ready, write only while the block is idle.
// Timing:
//   The multiplier works through 8 bits of the block per cycle, and each
//   block or finish holds it until all its bits are done; the accumulator
//   feedback allows no overlap, so a new block starts only once the
//   previous one is done. A four-entry command queue sits in front, so
//   input keeps being taken while the multiplier is busy; full rises once
//   the queue fills. With an idle engine, empty falls once a taken finish
//   has passed the queue and every multiplier step. If a result is not popped,
//   a later finish waits at the queue head and the rest wait until full rises.
// Reset: clears key, accumulator, byte counters, queue and result slot.
// ----------------------------------------------------------------------------
module ghash_accumulator #(
    parameter int LEN_COUNT_BITS = 61
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input queue
    input  logic                              push,
    output logic                              full,
    input  logic [1:0]                        i_op,
    input  logic [gha_pkg::HALF_BITS-1:0]     i_data_hi,
    input  logic [gha_pkg::HALF_BITS-1:0]     i_data_lo,
    input  logic [gha_pkg::COUNT_W-1:0]       i_byte_count,
    // result queue
    output logic                              empty,
    input  logic                              pop,
    output logic [gha_pkg::HALF_BITS-1:0]     o_hash_hi,
    output logic [gha_pkg::HALF_BITS-1:0]     o_hash_lo,
    // configuration
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [gha_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gha_pkg::HALF_BITS-1:0]     i_cfg_data
);

    logic [gha_pkg::HALF_BITS-1:0]  r_key_hi;
    logic [gha_pkg::HALF_BITS-1:0]  r_key_lo;

    logic                           cmd_push;
    gha_pkg::t_cmd                  cmd_in;
    logic                           q_full;
    logic                           q_valid;
    gha_pkg::t_cmd                  q_data;
    logic                           q_pop;
    logic                           res_valid;
    logic [gha_pkg::BLOCK_BITS-1:0] res;

    // key registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= '0;
            r_key_lo <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                gha_pkg::REG_KEY_HI: r_key_hi <= i_cfg_data;
                gha_pkg::REG_KEY_LO: r_key_lo <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front end: classify, pad, count
    gha_front #(
        .LEN_COUNT_BITS(LEN_COUNT_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (q_full),
        .i_op         (i_op),
        .i_data_hi    (i_data_hi),
        .i_data_lo    (i_data_lo),
        .i_byte_count (i_byte_count),
        .o_cmd_push   (cmd_push),
        .o_cmd        (cmd_in)
    );

    // command queue
    gha_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    // multiplier engine
    gha_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key       ({r_key_hi, r_key_lo}),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_data),
        .o_cmd_pop   (q_pop),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_pop   (pop)
    );

    assign full      = q_full;
    assign empty     = !res_valid;
    assign o_hash_hi = res[gha_pkg::BLOCK_BITS-1:gha_pkg::HALF_BITS];
    assign o_hash_lo = res[gha_pkg::HALF_BITS-1:0];

endmodule

[tb/ghash_accumulator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghash_accumulator_tb
// Self-checking bench for the GHASH accumulator. Blocks and finish commands
// are pushed through the input queue, and each one is also fed to a local
// GF(2^128) model. Every popped hash is compared against the oldest predicted
// one. The run covers directed padding and key cases, a long result-side stall
// that fills the input queue, and random messages under several hash keys.
// ----------------------------------------------------------------------------
module ghash_accumulator_tb;

    localparam int          LEN_BITS       = 61;
    localparam logic [1:0]  OP_UNUSED      = 2'd3;
    localparam logic [127:0] FIELD_POLY    = {8'hE1, 120'd0};
    localparam int          SETTLE_CYCLES  = 100;   // covers a full queue of 4 commands plus the result
    localparam int          STALL_LIMIT    = 2000;
    localparam int          HOLD_CYCLES    = 150;
    localparam int          RANDOM_ITEMS   = 400;
    localparam int          KEY_PHASE      = 100;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                push;
    logic                                full;
    logic [1:0]                          i_op;
    logic [gha_pkg::HALF_BITS-1:0]       i_data_hi;
    logic [gha_pkg::HALF_BITS-1:0]       i_data_lo;
    logic [gha_pkg::COUNT_W-1:0]         i_byte_count;
    logic                                empty;
    logic                                pop;
    logic [gha_pkg::HALF_BITS-1:0]       o_hash_hi;
    logic [gha_pkg::HALF_BITS-1:0]       o_hash_lo;
    logic                                i_cfg_valid;
    logic                                o_cfg_ready;
    logic [gha_pkg::CFG_IDX_W-1:0]       i_cfg_index;
    logic [gha_pkg::HALF_BITS-1:0]       i_cfg_data;

    // model state: key, accumulator, section byte counts
    logic [127:0]          hash_key;
    logic [127:0]          ghash_acc;
    logic [LEN_BITS-1:0]   aad_len;
    logic [LEN_BITS-1:0]   ct_len;
    logic [127:0]          expected_hashes[$];

    int unsigned           items_taken = 0;
    int unsigned           errors      = 0;
    int unsigned           hold_req    = 0;
    bit                    tx_idle     = 1'b1;
    bit                    rx_idle     = 1'b1;

    ghash_accumulator #(
        .LEN_COUNT_BITS(LEN_BITS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_op         (i_op),
        .i_data_hi    (i_data_hi),
        .i_data_lo    (i_data_lo),
        .i_byte_count (i_byte_count),
        .empty        (empty),
        .pop          (pop),
        .o_hash_hi    (o_hash_hi),
        .o_hash_lo    (o_hash_lo),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // GF(2^128) product, bit 0 of the field is the MSB of the vector
    function automatic logic [127:0] gf_mult(input logic [127:0] x, input logic [127:0] h);
        logic [127:0] z;
        logic [127:0] v;
        z = '0;
        v = h;
        for (int i = 0; i < 128; i++) begin
            if (x[127-i]) z ^= v;
            v = v[0] ? ((v >> 1) ^ FIELD_POLY) : (v >> 1);
        end
        return z;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // update the model with one accepted input transaction
    function automatic void predict_hash(input logic [1:0] op, input logic [63:0] hi,
                                         input logic [63:0] lo, input logic [4:0] cnt);
        logic [127:0] blk;
        logic [4:0]   n;
        n = cnt;
        if (op == gha_pkg::OP_FINISH) begin
            blk = {64'(aad_len) << 3, 64'(ct_len) << 3};
            ghash_acc = gf_mult(ghash_acc ^ blk, hash_key);
            expected_hashes.push_back(ghash_acc);
            ghash_acc = '0;
            aad_len   = '0;
            ct_len    = '0;
        end else if (op != OP_UNUSED && n != 0) begin
            if (n > gha_pkg::BLOCK_BYTES) n = 5'(gha_pkg::BLOCK_BYTES);
            blk = {hi, lo} & (~128'd0 << (8 * (gha_pkg::BLOCK_BYTES - n)));
            ghash_acc = gf_mult(ghash_acc ^ blk, hash_key);
            if (op == gha_pkg::OP_AAD) aad_len = aad_len + LEN_BITS'(n);
            else                       ct_len  = ct_len + LEN_BITS'(n);
        end
    endfunction

    // offer one item, after a random gap while tx_idle is set, return at the edge it is taken
    task automatic send_item(input logic [1:0] op, input logic [63:0] hi,
                             input logic [63:0] lo, input logic [4:0] cnt);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push         <= 1'b1;
        i_op         <= op;
        i_data_hi    <= hi;
        i_data_lo    <= lo;
        i_byte_count <= cnt;
        do @(posedge i_clk); while (full);
        predict_hash(op, hi, lo, cnt);
        items_taken++;
    endtask

    // config write, one transaction
    task automatic write_key_reg(input logic [gha_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == gha_pkg::REG_KEY_HI) hash_key[127:64] = val;
        else                            hash_key[63:0]   = val;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_hash_key(input logic [127:0] key);
        write_key_reg(gha_pkg::REG_KEY_HI, key[127:64]);
        write_key_reg(gha_pkg::REG_KEY_LO, key[63:0]);
    endtask

    // stop offering, let all hashes drain and the engine go quiet
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge i_clk);
        while (expected_hashes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // malformed, dropped or out-of-place items mixed into messages
    task automatic send_junk();
        logic [1:0] dop;
        dop = $urandom_range(0, 1) ? gha_pkg::OP_CIPHER : gha_pkg::OP_AAD;
        case ($urandom_range(0, 4))
            0: begin
                send_item(OP_UNUSED, rand64(), rand64(), 5'($urandom_range(0, 31)));
            end
            1: begin
                send_item(dop, rand64(), rand64(), 5'd0);
            end
            2: begin
                send_item(dop, rand64(), rand64(), 5'($urandom_range(17, 31)));
            end
            3: begin
                // short block in the middle of a section
                send_item(dop, rand64(), rand64(), 5'($urandom_range(1, 15)));
            end
            default: begin
                send_item(gha_pkg::OP_AAD, rand64(), rand64(), 5'($urandom_range(1, 16)));
            end
        endcase
    endtask

    // full blocks except a possibly short last one
    task automatic send_section_block(input logic [1:0] op, input bit last);
        logic [4:0] cnt;
        cnt = last ? 5'($urandom_range(1, 16)) : 5'(gha_pkg::BLOCK_BYTES);
        if ($urandom_range(0, 9) == 0) send_junk();
        send_item(op, rand64(), rand64(), cnt);
    endtask

    task automatic send_random_message();
        int unsigned n_aad;
        int unsigned n_ct;
        n_aad = $urandom_range(0, 3);
        n_ct  = $urandom_range(0, 5);
        for (int k = 0; k < n_aad; k++) send_section_block(gha_pkg::OP_AAD, k == n_aad - 1);
        for (int k = 0; k < n_ct; k++)  send_section_block(gha_pkg::OP_CIPHER, k == n_ct - 1);
        if ($urandom_range(0, 9) == 0) send_junk();
        send_item(gha_pkg::OP_FINISH, rand64(), rand64(), 5'($urandom_range(0, 31)));
    endtask

    // key is zero out of reset, so every hash is zero
    task automatic test_reset_state();
        send_item(gha_pkg::OP_AAD, rand64(), rand64(), 5'd16);
        send_item(gha_pkg::OP_CIPHER, rand64(), rand64(), 5'd5);
        send_item(gha_pkg::OP_FINISH, rand64(), rand64(), 5'd0);
        wait_idle();
    endtask

    // padding boundaries, dropped items, oversized counts, empty message
    task automatic test_block_padding();
        set_hash_key({rand64(), rand64()});
        send_item(gha_pkg::OP_AAD,    '1,       '1,       5'd16);
        send_item(gha_pkg::OP_AAD,    '1,       '1,       5'd1);
        send_item(gha_pkg::OP_CIPHER, '1,       '1,       5'd7);
        send_item(gha_pkg::OP_CIPHER, '1,       '1,       5'd8);
        send_item(gha_pkg::OP_CIPHER, rand64(), rand64(), 5'd9);
        send_item(gha_pkg::OP_CIPHER, rand64(), rand64(), 5'd15);
        send_item(gha_pkg::OP_CIPHER, '0,       '0,       5'd16);
        send_item(gha_pkg::OP_AAD,    rand64(), rand64(), 5'd0);
        send_item(gha_pkg::OP_CIPHER, '1,       '1,       5'd31);
        send_item(OP_UNUSED,          '1,       '1,       5'd16);
        send_item(gha_pkg::OP_AAD,    rand64(), rand64(), 5'd17);
        send_item(gha_pkg::OP_FINISH, '1,       '1,       5'd0);
        send_item(gha_pkg::OP_FINISH, rand64(), rand64(), 5'd31);
        wait_idle();
    endtask

    // field identity, all-ones key and the highest field bit
    task automatic test_key_extremes();
        logic [127:0] keys[3];
        keys[0] = {64'h8000_0000_0000_0000, 64'd0};
        keys[1] = '1;
        keys[2] = {64'd0, 64'd1};
        foreach (keys[k]) begin
            set_hash_key(keys[k]);
            send_item(gha_pkg::OP_AAD, rand64(), rand64(), 5'd12);
            send_item(gha_pkg::OP_CIPHER, '1, '1, 5'd16);
            send_item(gha_pkg::OP_FINISH, rand64(), rand64(), 5'd16);
            wait_idle();
        end
    endtask

    // result side stalls long while input keeps coming, input queue fills
    task automatic test_queue_backpressure();
        set_hash_key({rand64(), rand64()});
        tx_idle  = 1'b0;
        hold_req = HOLD_CYCLES;
        repeat (3) begin
            send_item(gha_pkg::OP_AAD, rand64(), rand64(), 5'd16);
            send_item(gha_pkg::OP_CIPHER, rand64(), rand64(), 5'd16);
            send_item(gha_pkg::OP_CIPHER, rand64(), rand64(), 5'($urandom_range(1, 16)));
            send_item(gha_pkg::OP_FINISH, rand64(), rand64(), 5'($urandom_range(0, 31)));
        end
        tx_idle = 1'b1;
        wait_idle();
    endtask

    // random messages, key changed between phases
    task automatic test_random_messages();
        int unsigned start;
        int unsigned mark;
        start = items_taken;
        mark  = items_taken;
        while (items_taken - start < RANDOM_ITEMS) begin
            if (items_taken - mark >= KEY_PHASE) begin
                wait_idle();
                case ($urandom_range(0, 5))
                    0:       set_hash_key('1);
                    1:       set_hash_key({64'h8000_0000_0000_0000, 64'd0});
                    2:       set_hash_key({64'd0, 64'd1});
                    default: set_hash_key({rand64(), rand64()});
                endcase
                mark = items_taken;
            end
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            send_random_message();
        end
        wait_idle();
    endtask

    // result side: pop with random gaps, long hold on request
    initial begin : result_sink
        int unsigned gap_left;
        gap_left = 0;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                gap_left = 0;
            end else if (hold_req != 0) begin
                pop <= 1'b0;
                gap_left = hold_req;
                hold_req = 0;
            end else if (pop && !empty) begin
                gap_left = rx_idle ? $urandom_range(0, 4) : 0;
                pop <= (gap_left == 0);
            end else if (gap_left != 0) begin
                gap_left--;
                if (gap_left == 0) pop <= 1'b1;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // compare each popped hash with the oldest prediction
    always @(posedge i_clk) begin : hash_check
        logic [127:0] want;
        if (i_rst_n && pop && !empty) begin
            if (expected_hashes.size() == 0) begin
                $display("%0t unexpected hash: expected none actual %h_%h",
                         $time, o_hash_hi, o_hash_lo);
                errors++;
            end else begin
                want = expected_hashes.pop_front();
                if (o_hash_hi !== want[127:64]) begin
                    $display("%0t hash_hi mismatch: expected %h actual %h",
                             $time, want[127:64], o_hash_hi);
                    errors++;
                end
                if (o_hash_lo !== want[63:0]) begin
                    $display("%0t hash_lo mismatch: expected %h actual %h",
                             $time, want[63:0], o_hash_lo);
                    errors++;
                end
            end
        end
    end

    // watchdog: too long without any transaction
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t timeout: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    // reset, then the tests in turn
    initial begin
        hash_key  = '0;
        ghash_acc = '0;
        aad_len   = '0;
        ct_len    = '0;
        i_rst_n      <= 1'b0;
        push         <= 1'b0;
        i_op         <= gha_pkg::OP_AAD;
        i_data_hi    <= '0;
        i_data_lo    <= '0;
        i_byte_count <= '0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= gha_pkg::REG_KEY_HI;
        i_cfg_data   <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_block_padding();
        test_key_extremes();
        test_queue_backpressure();
        test_random_messages();

        if (errors == 0 && expected_hashes.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/gha_pkg.sv
rtl/gha_front.sv
rtl/gha_fifo.sv
rtl/gha_engine.sv
rtl/ghash_accumulator.sv
tb/ghash_accumulator_tb.sv
